@@ hw/rtl/ogi_pkg.sv @@
// ----------------------------------------------------------------------------
// ogi_pkg
// Shared types and fixed field widths for the occupancy grid inflation core.
// ----------------------------------------------------------------------------
package ogi_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgDimW  = 11;
  localparam int unsigned CfgRadW  = 4;
  localparam int unsigned PosW     = 10;

  localparam logic [CfgDimW-1:0] GridWidthRst  = 11'd1024;
  localparam logic [CfgDimW-1:0] GridHeightRst = 11'd1024;
  localparam logic [CfgRadW-1:0] RadiusRst     = 4'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_RADIUS      = 2'd2
  } cfg_idx_e;

  typedef logic [PosW-1:0] pos_t;

endpackage

@@ hw/rtl/occupancy_grid_inflation_core.sv @@
// ----------------------------------------------------------------------------
// occupancy_grid_inflation_core
// Square-kernel dilation of a raster occupancy stream, centre cell excluded.
// ----------------------------------------------------------------------------
// One cell beat is taken every clock cycle while the result side is not
// stalled; a cell's result is registered in stage one and then in the
// result register. Each column keeps its last 2*MAX_RADIUS+1 rows in a
// line-buffer memory of MAX_WIDTH entries that is read when a cell is taken
// and written back as that cell moves on to the result register, with a
// forward path for the case of the same column being hit twice in a row. A
// shift line of column words forms the square, so the rate is set by that
// single read-modify-write of the line buffer. Interior cells give one result
// each; border cells give none. The line buffer needs no clearing: rows older
// than the current frame never reach a result.
module occupancy_grid_inflation_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RADIUS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ogi_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ogi_pkg::CfgDataW-1:0]  cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_occupied_i,
  input  logic                          in_frame_start_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ogi_pkg::pos_t                 out_row_o,
  output ogi_pkg::pos_t                 out_col_o,
  output logic                          out_blocked_o
);
  import ogi_pkg::*;

  localparam int unsigned Win  = 2 * MAX_RADIUS + 1;
  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned WdW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HtW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RadW = $clog2(MAX_RADIUS + 1);

  // configuration
  logic [CfgDimW-1:0] grid_width_q, grid_height_q;
  logic [CfgRadW-1:0] radius_q;
  logic [WdW-1:0]     w_eff;
  logic [HtW-1:0]     h_eff;
  logic [RadW-1:0]    r_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridWidthRst;
      grid_height_q <= GridHeightRst;
      radius_q      <= RadiusRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[CfgDimW-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[CfgDimW-1:0];
        CFG_RADIUS:      radius_q      <= cfg_data_i[CfgRadW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = WdW'(1);
    end else if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WdW'(MAX_WIDTH);
    end else begin
      w_eff = WdW'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      h_eff = HtW'(1);
    end else if (32'(grid_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HtW'(MAX_HEIGHT);
    end else begin
      h_eff = HtW'(grid_height_q);
    end
    if (32'(radius_q) > 32'(MAX_RADIUS)) begin
      r_eff = RadW'(MAX_RADIUS);
    end else begin
      r_eff = RadW'(radius_q);
    end
  end

  // handshake
  logic s1_valid_q, s1_adv, in_acc, out_free;
  logic out_valid_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // position counters
  logic [ColW-1:0] col_cnt_q, col_cnt_d, in_col;
  logic [RowW-1:0] row_cnt_q, row_cnt_d, in_row;

  always_comb begin
    in_col = in_frame_start_i ? '0 : col_cnt_q;
    in_row = in_frame_start_i ? '0 : row_cnt_q;
    if (WdW'(in_col) + WdW'(1) >= w_eff) begin
      col_cnt_d = '0;
      row_cnt_d = (HtW'(in_row) + HtW'(1) >= h_eff) ? '0 : in_row + RowW'(1);
    end else begin
      col_cnt_d = in_col + ColW'(1);
      row_cnt_d = (HtW'(in_row) >= h_eff) ? '0 : in_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // stage one: line-buffer read data and cell
  logic [Win-1:0]  mem [MAX_WIDTH];
  logic [Win-1:0]  rd_q, byp_data_q, hist, column;
  logic            byp_hit_q;
  logic            s1_occ_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;

  assign hist   = byp_hit_q ? byp_data_q : rd_q;
  assign column = {hist[Win-2:0], s1_occ_q};

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem[s1_col_q] <= column;
    end
    if (in_acc) begin
      rd_q       <= mem[in_col];
      byp_hit_q  <= s1_adv && (s1_col_q == in_col);
      byp_data_q <= column;
      s1_occ_q   <= in_occupied_i;
      s1_col_q   <= in_col;
      s1_row_q   <= in_row;
    end
  end

  // square window
  logic [Win-1:0] win_q [Win];
  logic [Win-1:0] win_d [Win];
  logic           blocked, emit;

  always_comb begin
    win_d[0] = column;
    for (int k = 1; k < Win; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Win; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < Win; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  always_comb begin
    blocked = 1'b0;
    for (int k = 0; k < Win; k++) begin
      for (int j = 0; j < Win; j++) begin
        if (k <= 2 * int'(r_eff) && j <= 2 * int'(r_eff) &&
            !(k == int'(r_eff) && j == int'(r_eff)) && win_d[k][j]) begin
          blocked = 1'b1;
        end
      end
    end
    emit = (HtW'(s1_row_q) < h_eff) && (WdW'(s1_col_q) < w_eff) &&
           (32'(s1_row_q) >= 2 * 32'(r_eff)) && (32'(s1_col_q) >= 2 * 32'(r_eff));
  end

  // result register
  logic [RowW:0] row_diff;
  logic [ColW:0] col_diff;
  pos_t          out_row_q, out_col_q;
  logic          out_blocked_q;

  assign row_diff = {1'b0, s1_row_q} - (RowW + 1)'(r_eff);
  assign col_diff = {1'b0, s1_col_q} - (ColW + 1)'(r_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_row_q     <= PosW'(row_diff);
      out_col_q     <= PosW'(col_diff);
      out_blocked_q <= blocked;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_blocked_o = out_blocked_q;

endmodule
